// ===== src/tts_pkg.sv =====
package tts_pkg;

	typedef logic [7:0] byte_t;

	localparam int unsigned OPEN_LEN  = 7;
	localparam int unsigned CLOSE_LEN = 8;

	localparam byte_t LT_CHAR = 8'h3C;

	localparam byte_t OPEN_TAG [0:7] = '{
		8'h3C, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E, 8'h00
	};
	localparam byte_t CLOSE_TAG [0:7] = '{
		8'h3C, 8'h2F, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E
	};

	localparam logic CFG_SPLIT_ENABLE       = 1'b0;
	localparam logic CFG_START_IN_REASONING = 1'b1;

	typedef struct packed {
		logic split_enable;
		logic start_in_reasoning;
	} cfg_t;

	// one item's worth of results: replayed tag prefix, then optional byte
	typedef struct packed {
		logic [2:0] rep_cnt;
		logic       close_sel;
		logic       chan;
		logic       has_byte;
		byte_t      data;
	} burst_t;

	function automatic byte_t tag_char(input logic close_sel, input logic [2:0] idx);
		byte_t c;
		if (close_sel) begin
			c = CLOSE_TAG[idx];
		end else begin
			c = OPEN_TAG[idx];
		end
		return c;
	endfunction

endpackage

// ===== src/tts_stream_if.sv =====
interface tts_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       flush_item;

	modport source (output valid, output text_byte, output flush_item, input ready);
	modport sink (input valid, input text_byte, input flush_item, output ready);
endinterface

interface tts_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       channel;
	logic       last_of_run;

	modport source (output valid, output out_byte, output channel, output last_of_run,
		input ready);
	modport sink (input valid, input out_byte, input channel, input last_of_run,
		output ready);
endinterface

// ===== src/tts_matcher.sv =====
module tts_matcher (
	input  logic          clk,
	input  logic          arst_n,
	tts_item_if.sink      item_ch,
	input  tts_pkg::cfg_t cfg,
	input  logic          burst_free,
	output logic          load,
	output tts_pkg::burst_t desc
);
	import tts_pkg::*;

	logic       valid_s1;
	byte_t      byte_s1;
	logic       flush_s1;

	logic       mode_q;
	logic [2:0] cnt_q;
	logic       mode_d;
	logic [2:0] cnt_d;

	logic       adv;
	logic       empty;
	logic       last_char;

	always_comb begin
		desc           = '0;
		desc.close_sel = mode_q;
		desc.chan      = mode_q;
		desc.data      = byte_s1;
		mode_d         = mode_q;
		cnt_d          = cnt_q;
		last_char      = mode_q ? (cnt_q == 3'(CLOSE_LEN - 1)) : (cnt_q == 3'(OPEN_LEN - 1));

		if (flush_s1) begin
			desc.rep_cnt = cnt_q;
			desc.chan    = cfg.split_enable & mode_q;
			cnt_d        = '0;
			mode_d       = cfg.start_in_reasoning;
		end else if (!cfg.split_enable) begin
			desc.rep_cnt  = cnt_q;
			desc.chan     = 1'b0;
			desc.has_byte = 1'b1;
			cnt_d         = '0;
		end else if (byte_s1 == tag_char(mode_q, cnt_q)) begin
			if (last_char) begin
				mode_d = ~mode_q;
				cnt_d  = '0;
			end else begin
				cnt_d = cnt_q + 3'd1;
			end
		end else begin
			desc.rep_cnt = cnt_q;
			if (byte_s1 == LT_CHAR) begin
				cnt_d = 3'd1;
			end else begin
				desc.has_byte = 1'b1;
				cnt_d         = '0;
			end
		end
	end

	assign empty         = (desc.rep_cnt == '0) && !desc.has_byte;
	assign adv           = valid_s1 && (empty || burst_free);
	assign load          = adv && !empty;
	assign item_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				mode_q <= mode_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) begin
			byte_s1  <= item_ch.text_byte;
			flush_s1 <= item_ch.flush_item;
		end
	end

	// open tag never holds its full length
	a_open_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q || (cnt_q != 3'd7))
		else $error("open tag match count out of range");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(mode_q) && $stable(cnt_q)))
		else $error("match state moved without an item");

endmodule

// ===== src/tts_burst.sv =====
module tts_burst (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  tts_pkg::burst_t desc,
	output logic            burst_free,
	tts_result_if.source    result_ch
);
	import tts_pkg::*;

	logic [2:0] rep_q;
	logic [2:0] idx_q;
	logic       has_q;
	logic       sel_q;
	logic       chan_q;
	byte_t      data_q;

	logic busy;
	logic last;
	logic xfer;

	assign busy = (rep_q != '0) || has_q;
	assign last = (rep_q == '0) || ((rep_q == 3'd1) && !has_q);
	assign xfer = result_ch.valid && result_ch.ready;

	assign result_ch.valid       = busy;
	assign result_ch.out_byte    = (rep_q != '0) ? tag_char(sel_q, idx_q) : data_q;
	assign result_ch.channel     = chan_q;
	assign result_ch.last_of_run = last;

	assign burst_free = !busy || (xfer && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= '0;
			has_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			rep_q <= desc.rep_cnt;
			has_q <= desc.has_byte;
			idx_q <= '0;
		end else if (xfer) begin
			if (rep_q != '0) begin
				rep_q <= rep_q - 3'd1;
				idx_q <= idx_q + 3'd1;
			end else begin
				has_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sel_q  <= desc.close_sel;
			chan_q <= desc.chan;
			data_q <= desc.data;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> burst_free)
		else $error("burst loaded while busy");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy)
		else $error("loaded burst produced no transfer");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, idx_q} + {1'b0, rep_q}) <= 4'd7)
		else $error("replay index past held prefix");

endmodule

// ===== src/think_tag_stream_splitter.sv =====
// Think-tag stream splitter.
// item_ch carries one text byte per transfer, or a flush marker (flush_item=1,
// text_byte ignored). With split_enable set, result_ch carries the bytes with
// <think> and </think> removed, each labeled content (channel 0) or reasoning
// (channel 1); otherwise all bytes pass on channel 0. last_of_run marks the
// final result caused by an item. Bytes that may start a tag are held; a
// mismatch replays them, then the byte, or holds the byte if it is <. A flush
// emits held bytes and reloads the start mode. Items that complete or extend a
// tag give no results. Config: cfg_we/cfg_idx/cfg_data, index 0 split_enable,
// 1 start_in_reasoning; write only while idle.
// Each item's first result passes the input register, then the result
// register. Items giving 0 or 1 results sustain one item per cycle while
// result_ch is ready; an item giving several results holds the result
// register while it sends them, one byte per cycle while result_ch is ready.
// Reset: no match held, content mode, split enabled. A stalled receiver holds
// the result register; items giving no results still pass, but the next item
// giving results waits in the input register, then item_ch.ready drops.
module think_tag_stream_splitter (
	input  logic          clk,
	input  logic          arst_n,
	tts_item_if.sink      item_ch,
	tts_result_if.source  result_ch,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic          cfg_data
);
	import tts_pkg::*;

	cfg_t   cfg_q;
	logic   burst_free;
	logic   load;
	burst_t desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.split_enable       <= 1'b1;
			cfg_q.start_in_reasoning <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SPLIT_ENABLE:       cfg_q.split_enable       <= cfg_data;
				CFG_START_IN_REASONING: cfg_q.start_in_reasoning <= cfg_data;
				default: ;
			endcase
		end
	end

	tts_matcher u_matcher (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_ch    (item_ch),
		.cfg        (cfg_q),
		.burst_free (burst_free),
		.load       (load),
		.desc       (desc)
	);

	tts_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.desc       (desc),
		.burst_free (burst_free),
		.result_ch  (result_ch)
	);

endmodule
